// ----- hdl/rgb_hls_color_converter_macros.svh -----
// ----------------------------------------------------------------------------
// RGB/HLS converter assertion macros
// Shared concurrent assertion shorthands, clocked on clk_i, off during reset.
// ----------------------------------------------------------------------------
`ifndef RGB_HLS_COLOR_CONVERTER_MACROS_SVH
`define RGB_HLS_COLOR_CONVERTER_MACROS_SVH

// same-cycle implication
`define RHC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RHC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/rhc_pkg.sv -----
// ----------------------------------------------------------------------------
// RGB/HLS converter package
// Scale constants, code types and constant-divisor helpers.
// ----------------------------------------------------------------------------
package rhc_pkg;

  localparam int unsigned HLS_MAX   = 252;
  localparam int unsigned RGB_MAX   = 255;
  localparam int unsigned GRAY_HUE  = HLS_MAX * 2 / 3;
  localparam int unsigned SIXTH     = HLS_MAX / 6;
  localparam int unsigned TWELFTH   = HLS_MAX / 12;
  localparam int unsigned HUE_THIRD = HLS_MAX / 3;
  localparam int unsigned HLS_HALF  = HLS_MAX / 2;

  localparam int unsigned DIV_BITS  = 8;
  localparam int unsigned DIV_FIRST = 4;
  localparam int unsigned DIV_LAST  = DIV_FIRST + DIV_BITS - 1;
  localparam int unsigned NUM_STG   = DIV_LAST + 2;

  typedef enum logic [1:0] {
    MAX_R,
    MAX_G,
    MAX_B
  } maxsel_e;

  typedef enum logic [1:0] {
    SEG_RISE,
    SEG_HI,
    SEG_FALL,
    SEG_LO
  } seg_e;

  // x / 510 for x below 256*510: reciprocal estimate plus one correction
  function automatic logic [7:0] div510(input logic [16:0] x);
    logic [25:0] p;
    logic [8:0]  q0;
    logic [17:0] r;
    p  = 26'(x) * 26'd257;
    q0 = p[25:17];
    r  = 18'(x) - 18'(q0) * 18'(2 * RGB_MAX);
    return (r >= 18'(2 * RGB_MAX)) ? 8'(q0 + 9'd1) : 8'(q0);
  endfunction

  // x / 252 for x below 256*252
  function automatic logic [7:0] div252(input logic [15:0] x);
    logic [24:0] p;
    logic [8:0]  q0;
    logic [16:0] r;
    p  = 25'(x) * 25'd260;
    q0 = p[24:16];
    r  = 17'(x) - 17'(q0) * 17'(HLS_MAX);
    return (r >= 17'(HLS_MAX)) ? 8'(q0 + 9'd1) : 8'(q0);
  endfunction

  // x / 42 for x below 256*42
  function automatic logic [7:0] div42(input logic [13:0] x);
    logic [24:0] p;
    logic [8:0]  q0;
    logic [14:0] r;
    p  = 25'(x) * 25'd1560;
    q0 = p[24:16];
    r  = 15'(x) - 15'(q0) * 15'(SIXTH);
    return (r >= 15'(SIXTH)) ? 8'(q0 + 9'd1) : 8'(q0);
  endfunction

endpackage

// ----- hdl/rhc_if.sv -----
// ----------------------------------------------------------------------------
// RGB/HLS converter channels
// Request and response valid/ready channels with their payload.
// ----------------------------------------------------------------------------
interface rhc_req_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [23:0] rgb_in;
  logic [7:0]  hue_in;
  logic [7:0]  lightness_in;
  logic [7:0]  saturation_in;

  modport source (output valid, req_type, rgb_in, hue_in, lightness_in, saturation_in,
                  input ready);
  modport sink   (input valid, req_type, rgb_in, hue_in, lightness_in, saturation_in,
                  output ready);
endinterface

interface rhc_rsp_if;
  logic        valid;
  logic        ready;
  logic [23:0] rgb_out;
  logic [7:0]  hue_out;
  logic [7:0]  lightness_out;
  logic [7:0]  saturation_out;

  modport source (output valid, rgb_out, hue_out, lightness_out, saturation_out,
                  input ready);
  modport sink   (input valid, rgb_out, hue_out, lightness_out, saturation_out,
                  output ready);
endinterface

// ----- hdl/rgb_hls_color_converter.sv -----
// ----------------------------------------------------------------------------
// RGB/HLS color converter
// Requests enter on req_i, one result per request leaves on rsp_o.
// req_type 0 splits a packed color into hue, lightness and saturation on a
// 0..252 scale; req_type 1 rebuilds the packed color from those three.
// The fields the chosen direction does not produce come out as zero.
// A request transfer lands in a 13-stage pipeline whose last stage drives
// rsp_o; one request per cycle is taken while rsp_o.ready stays high.
// The depth comes from the saturation and hue divisions, which resolve one
// quotient bit per stage over eight stages.
// Each stage carries a valid bit and advances when it is empty or its
// successor advances, so bubbles close up while the receiver stalls and
// req_i.ready drops only when every stage holds an item.
// Reset empties the pipeline; no state survives between requests.
// ----------------------------------------------------------------------------
`include "rgb_hls_color_converter_macros.svh"

module rgb_hls_color_converter
  import rhc_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  rhc_req_if.sink  req_i,
  rhc_rsp_if.source rsp_o
);

  typedef struct packed {
    logic              req;
    logic [7:0]        r;
    logic [7:0]        g;
    logic [7:0]        b;
    logic [7:0]        mx;
    logic [7:0]        mn;
    logic [7:0]        d;
    logic [8:0]        sum;
    maxsel_e           msel;
    logic [16:0]       lnum;
    logic [7:0]        lum;
    logic [16:0]       srem;
    logic [8:0]        sdiv;
    logic [7:0]        squo;
    logic [2:0][16:0]  hrem;
    logic [2:0][7:0]   hquo;
    logic [7:0]        in_h;
    logic [7:0]        in_l;
    logic [7:0]        in_s;
    logic              zsat;
    logic [16:0]       mprod;
    logic [7:0]        m1;
    logic [7:0]        m2;
    seg_e [2:0]        seg;
    logic [2:0][13:0]  cnum;
    logic [2:0][7:0]   cval;
    logic [2:0][15:0]  bnum;
    logic [2:0][7:0]   cbyte;
    logic [23:0]       rgb_res;
    logic [7:0]        hue_res;
    logic [7:0]        lum_res;
    logic [7:0]        sat_res;
  } pipe_t;

  localparam int unsigned LAST = NUM_STG - 1;

  pipe_t              st_q [NUM_STG];
  pipe_t              st_d [NUM_STG];
  logic [NUM_STG-1:0] vld_q;
  logic [NUM_STG-1:0] adv;

  always_comb begin
    adv[LAST] = !vld_q[LAST] || rsp_o.ready;
    for (int k = LAST - 1; k >= 0; k--) begin
      adv[k] = !vld_q[k] || adv[k+1];
    end
  end

  assign req_i.ready = adv[0];

  // min/max, input saturation
  always_comb begin
    st_d[0]      = '0;
    st_d[0].req  = req_i.req_type;
    st_d[0].r    = req_i.rgb_in[7:0];
    st_d[0].g    = req_i.rgb_in[15:8];
    st_d[0].b    = req_i.rgb_in[23:16];
    if (st_d[0].r >= st_d[0].g && st_d[0].r >= st_d[0].b) begin
      st_d[0].mx   = st_d[0].r;
      st_d[0].msel = MAX_R;
    end else if (st_d[0].g >= st_d[0].b) begin
      st_d[0].mx   = st_d[0].g;
      st_d[0].msel = MAX_G;
    end else begin
      st_d[0].mx   = st_d[0].b;
      st_d[0].msel = MAX_B;
    end
    if (st_d[0].r <= st_d[0].g && st_d[0].r <= st_d[0].b) begin
      st_d[0].mn = st_d[0].r;
    end else if (st_d[0].g <= st_d[0].b) begin
      st_d[0].mn = st_d[0].g;
    end else begin
      st_d[0].mn = st_d[0].b;
    end
    st_d[0].sum  = 9'(st_d[0].mx) + 9'(st_d[0].mn);
    st_d[0].d    = st_d[0].mx - st_d[0].mn;
    st_d[0].in_h = (req_i.hue_in > 8'(HLS_MAX)) ? 8'(HLS_MAX) : req_i.hue_in;
    st_d[0].in_l = (req_i.lightness_in > 8'(HLS_MAX)) ? 8'(HLS_MAX) : req_i.lightness_in;
    st_d[0].in_s = (req_i.saturation_in > 8'(HLS_MAX)) ? 8'(HLS_MAX) : req_i.saturation_in;
    st_d[0].zsat = (st_d[0].in_s == 8'd0);
  end

  // lightness numerator, hue numerators, magic-value product
  always_comb begin
    st_d[1]      = st_q[0];
    st_d[1].lnum = 17'(st_q[0].sum) * 17'(HLS_MAX) + 17'(RGB_MAX);
    st_d[1].hrem[0] = 17'(st_q[0].mx - st_q[0].r) * 17'(SIXTH) + 17'(st_q[0].d >> 1);
    st_d[1].hrem[1] = 17'(st_q[0].mx - st_q[0].g) * 17'(SIXTH) + 17'(st_q[0].d >> 1);
    st_d[1].hrem[2] = 17'(st_q[0].mx - st_q[0].b) * 17'(SIXTH) + 17'(st_q[0].d >> 1);
    if (st_q[0].in_l <= 8'(HLS_HALF)) begin
      st_d[1].mprod = 17'(st_q[0].in_l) * (17'(HLS_MAX) + 17'(st_q[0].in_s))
                    + 17'(HLS_HALF);
    end else begin
      st_d[1].mprod = 17'(st_q[0].in_l) * 17'(st_q[0].in_s) + 17'(HLS_HALF);
    end
  end

  // lightness, magic values
  always_comb begin
    logic [7:0] q;
    st_d[2]     = st_q[1];
    st_d[2].lum = div510(st_q[1].lnum);
    q           = div252(st_q[1].mprod[15:0]);
    if (st_q[1].in_l <= 8'(HLS_HALF)) begin
      st_d[2].m2 = q;
    end else begin
      st_d[2].m2 = 8'(9'(st_q[1].in_l) + 9'(st_q[1].in_s) - 9'(q));
    end
    st_d[2].m1 = 8'(10'(st_q[1].in_l) * 10'd2 - 10'(st_d[2].m2));
  end

  // saturation divider setup, hue segment per channel
  always_comb begin
    logic signed [10:0] hv;
    logic signed [10:0] off;
    logic [5:0]         t;
    logic [7:0]         span;
    st_d[3] = st_q[2];
    if (st_q[2].lum <= 8'(HLS_HALF)) begin
      st_d[3].sdiv = st_q[2].sum;
    end else begin
      st_d[3].sdiv = 9'(2 * RGB_MAX) - st_q[2].sum;
    end
    st_d[3].srem = 17'(st_q[2].d) * 17'(HLS_MAX) + 17'(st_d[3].sdiv >> 1);
    st_d[3].squo = '0;
    st_d[3].hquo = '0;
    span         = st_q[2].m2 - st_q[2].m1;
    for (int c = 0; c < 3; c++) begin
      off = (c == 0) ? signed'(11'(HUE_THIRD)) :
            (c == 1) ? 11'sd0 : -signed'(11'(HUE_THIRD));
      hv  = signed'({3'b000, st_q[2].in_h}) + off;
      if (hv < 11'sd0) begin
        hv = hv + signed'(11'(HLS_MAX));
      end
      if (hv > signed'(11'(HLS_MAX))) begin
        hv = hv - signed'(11'(HLS_MAX));
      end
      if (hv < signed'(11'(SIXTH))) begin
        st_d[3].seg[c] = SEG_RISE;
        t              = 6'(hv);
      end else if (hv < signed'(11'(HLS_HALF))) begin
        st_d[3].seg[c] = SEG_HI;
        t              = '0;
      end else if (hv < signed'(11'(GRAY_HUE))) begin
        st_d[3].seg[c] = SEG_FALL;
        t              = 6'(signed'(11'(GRAY_HUE)) - hv);
      end else begin
        st_d[3].seg[c] = SEG_LO;
        t              = '0;
      end
      st_d[3].cnum[c] = 14'(14'(span) * 14'(t) + 14'(TWELFTH));
    end
  end

  // one quotient bit per stage; color rebuild rides alongside
  for (genvar k = DIV_FIRST; k <= DIV_LAST; k++) begin : g_div
    localparam int unsigned BIT = DIV_LAST - k;
    always_comb begin
      logic [16:0] sd;
      logic [16:0] hd;
      st_d[k] = st_q[k-1];
      sd = 17'(st_q[k-1].sdiv) << BIT;
      hd = 17'(st_q[k-1].d) << BIT;
      if (st_q[k-1].srem >= sd) begin
        st_d[k].srem      = st_q[k-1].srem - sd;
        st_d[k].squo[BIT] = 1'b1;
      end
      for (int c = 0; c < 3; c++) begin
        if (st_q[k-1].hrem[c] >= hd) begin
          st_d[k].hrem[c]      = st_q[k-1].hrem[c] - hd;
          st_d[k].hquo[c][BIT] = 1'b1;
        end
      end
      if (k == DIV_FIRST) begin
        for (int c = 0; c < 3; c++) begin
          case (st_q[k-1].seg[c])
            SEG_RISE, SEG_FALL: st_d[k].cval[c] = st_q[k-1].m1 + div42(st_q[k-1].cnum[c]);
            SEG_HI:             st_d[k].cval[c] = st_q[k-1].m2;
            default:            st_d[k].cval[c] = st_q[k-1].m1;
          endcase
        end
      end
      if (k == DIV_FIRST + 1) begin
        for (int c = 0; c < 3; c++) begin
          if (st_q[k-1].zsat) begin
            st_d[k].bnum[c] = 16'(st_q[k-1].in_l) * 16'(RGB_MAX);
          end else begin
            st_d[k].bnum[c] = 16'(st_q[k-1].cval[c]) * 16'(RGB_MAX) + 16'(HLS_HALF);
          end
        end
      end
      if (k == DIV_FIRST + 2) begin
        for (int c = 0; c < 3; c++) begin
          st_d[k].cbyte[c] = div252(st_q[k-1].bnum[c]);
        end
      end
    end
  end

  // hue combine, wrap, gray case, result select
  always_comb begin
    logic signed [9:0] h;
    logic signed [9:0] dr;
    logic signed [9:0] dg;
    logic signed [9:0] db;
    st_d[LAST] = st_q[LAST-1];
    dr = signed'({2'b00, st_q[LAST-1].hquo[0]});
    dg = signed'({2'b00, st_q[LAST-1].hquo[1]});
    db = signed'({2'b00, st_q[LAST-1].hquo[2]});
    case (st_q[LAST-1].msel)
      MAX_R:   h = db - dg;
      MAX_G:   h = signed'(10'(HUE_THIRD)) + dr - db;
      default: h = signed'(10'(2 * HUE_THIRD)) + dg - dr;
    endcase
    if (h < 10'sd0) begin
      h = h + signed'(10'(HLS_MAX));
    end
    if (h > signed'(10'(HLS_MAX))) begin
      h = h - signed'(10'(HLS_MAX));
    end
    if (st_q[LAST-1].req) begin
      st_d[LAST].rgb_res = {st_q[LAST-1].cbyte[2], st_q[LAST-1].cbyte[1],
                            st_q[LAST-1].cbyte[0]};
      st_d[LAST].hue_res = '0;
      st_d[LAST].lum_res = '0;
      st_d[LAST].sat_res = '0;
    end else begin
      st_d[LAST].rgb_res = '0;
      st_d[LAST].lum_res = st_q[LAST-1].lum;
      if (st_q[LAST-1].mx == st_q[LAST-1].mn) begin
        st_d[LAST].hue_res = 8'(GRAY_HUE);
        st_d[LAST].sat_res = '0;
      end else begin
        st_d[LAST].hue_res = 8'(h);
        st_d[LAST].sat_res = st_q[LAST-1].squo;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 0; k < NUM_STG; k++) begin
        if (adv[k]) begin
          vld_q[k] <= (k == 0) ? req_i.valid : vld_q[(k == 0) ? 0 : k - 1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NUM_STG; k++) begin
      if (adv[k]) begin
        st_q[k] <= st_d[k];
      end
    end
  end

  assign rsp_o.valid          = vld_q[LAST];
  assign rsp_o.rgb_out        = st_q[LAST].rgb_res;
  assign rsp_o.hue_out        = st_q[LAST].hue_res;
  assign rsp_o.lightness_out  = st_q[LAST].lum_res;
  assign rsp_o.saturation_out = st_q[LAST].sat_res;

  `RHC_ASSERT_NXT(a_transfer_enters, req_i.valid && req_i.ready, vld_q[0], "transfer dropped at entry")
  `RHC_ASSERT_IMP(a_hls_fields, rsp_o.valid && !st_q[LAST].req, rsp_o.rgb_out == 24'd0 && rsp_o.saturation_out <= 8'(HLS_MAX) && rsp_o.hue_out <= 8'(HLS_MAX), "bad HLS result")
  `RHC_ASSERT_IMP(a_rgb_fields, rsp_o.valid && st_q[LAST].req, rsp_o.hue_out == 8'd0 && rsp_o.lightness_out == 8'd0 && rsp_o.saturation_out == 8'd0, "bad RGB result")

endmodule
